/* design/n2a_pkg.sv */
// Package for number_to_ascii_digits: transaction types, format codes,
// ASCII constants and the decimal weight table. No dependencies.
package n2a_pkg;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic       last_char;
	} res_t;

	typedef enum logic [2:0] {
		FMT_DEC3 = 3'd0,
		FMT_DEC2 = 3'd1,
		FMT_BCD2 = 3'd2,
		FMT_HEX2 = 3'd3,
		FMT_DEC5 = 3'd4,
		FMT_HEX4 = 3'd5
	} fmt_t;

	localparam logic [6:0] ASCII_ZERO = 7'd48;
	localparam logic [6:0] ASCII_NINE = 7'd57;
	localparam logic [6:0] HEX_GAP    = 7'd7;

	// k * 10^place, place 0..4, k 0..9
	function automatic logic [16:0] dec_weight(input logic [2:0] place, input logic [3:0] k);
		logic [16:0] base;
		case (place)
			3'd0: base = 17'd1;
			3'd1: base = 17'd10;
			3'd2: base = 17'd100;
			3'd3: base = 17'd1000;
			3'd4: base = 17'd10000;
			default: base = 17'd0;
		endcase
		return 17'(base * {13'd0, k});
	endfunction

endpackage

/* design/n2a_digit.sv */
// Character extraction for one output position: decimal digit by weight
// compare and subtract, or hex/BCD nibble select. Uses n2a_pkg.
module n2a_digit import n2a_pkg::*; (
	input  logic [2:0]  fmt,
	input  logic [15:0] rem,
	input  logic [2:0]  left,
	output logic [6:0]  ascii_char,
	output logic [15:0] rem_next
);

	logic [3:0]  dig;
	logic [3:0]  nib;
	logic [16:0] sub;
	logic [6:0]  hex_c;

	always_comb begin
		dig = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if ({1'b0, rem} >= dec_weight(left, 4'(k))) begin
				dig = 4'(k);
			end
		end
		sub = dec_weight(left, dig);
		nib = rem[{left[1:0], 2'b00} +: 4];
		hex_c = ASCII_ZERO + {3'd0, nib};
		if (hex_c > ASCII_NINE) begin
			hex_c = hex_c + HEX_GAP;
		end

		rem_next = rem;
		case (fmt)
			FMT_DEC3, FMT_DEC2, FMT_DEC5: begin
				ascii_char = ASCII_ZERO + {3'd0, dig};
				rem_next   = rem - sub[15:0];
			end
			FMT_BCD2: begin
				ascii_char = (nib <= 4'd9) ? ASCII_ZERO + {3'd0, nib} : ASCII_ZERO;
			end
			FMT_HEX2, FMT_HEX4: begin
				ascii_char = hex_c;
			end
			default: begin
				ascii_char = ASCII_ZERO;
			end
		endcase
	end

endmodule

/* design/n2a_emit.sv */
// Character sequencer: loads a request, emits one character per cycle
// into the result register. Uses n2a_pkg and n2a_digit.
module n2a_emit import n2a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  req_t in_req,
	output logic take,
	output logic strobe,
	output res_t result
);

	logic        active_q;
	logic [2:0]  fmt_q;
	logic [15:0] rem_q;
	logic [2:0]  left_q;
	logic        strobe_q;
	res_t        result_q;

	logic [6:0]  ch;
	logic [15:0] rem_next;
	logic [7:0]  v8;
	logic [7:0]  v8_mod100;
	logic        init_ok;
	logic [15:0] init_rem;
	logic [2:0]  init_left;

	n2a_digit u_digit (
		.fmt       (fmt_q),
		.rem       (rem_q),
		.left      (left_q),
		.ascii_char(ch),
		.rem_next  (rem_next)
	);

	assign take = !active_q || (left_q == 3'd0);

	always_comb begin
		v8 = in_req.value[7:0];
		if (v8 >= 8'd200) begin
			v8_mod100 = v8 - 8'd200;
		end else if (v8 >= 8'd100) begin
			v8_mod100 = v8 - 8'd100;
		end else begin
			v8_mod100 = v8;
		end
		init_ok   = 1'b1;
		init_rem  = {8'd0, v8};
		init_left = 3'd1;
		case (in_req.req_type)
			FMT_DEC3: begin
				init_left = 3'd2;
			end
			FMT_DEC2: begin
				init_rem = {8'd0, v8_mod100};
			end
			FMT_BCD2, FMT_HEX2: begin
				init_left = 3'd1;
			end
			FMT_DEC5: begin
				init_rem  = in_req.value;
				init_left = 3'd4;
			end
			FMT_HEX4: begin
				init_rem  = in_req.value;
				init_left = 3'd3;
			end
			default: begin
				init_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (take) begin
				active_q <= in_valid && init_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q.ascii_char <= ch;
			result_q.last_char  <= (left_q == 3'd0);
		end
		if (take) begin
			fmt_q  <= in_req.req_type;
			rem_q  <= init_rem;
			left_q <= init_left;
		end else begin
			rem_q  <= rem_next;
			left_q <= left_q - 3'd1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

/* design/number_to_ascii_digits.sv */
// Top level of number_to_ascii_digits: request register and character
// sequencer. Uses n2a_pkg and n2a_emit.
//
// Usage: a request (format code and 16-bit value) is taken at a rising edge
// where start is high and busy is low. The block answers with one character
// per cycle on result, each marked by strobe for exactly one cycle, most
// significant first, last_char set on the final one. Formats give 3, 2, 2,
// 2, 5 and 4 characters; codes 6 and 7 give none.
// The accepting edge fills the input register, the idle sequencer then
// loads the request, and the result register takes the first character
// after that. Throughput: one character per cycle; each request holds
// the sequencer until all its characters (5 for dec5) are out. The
// character sequencer is the limit; one request waits in the input register
// while the previous one is being emitted, and busy is high only while
// that register is full and cannot move on.
// Reset clears the input register and sequencer; no results are pending.
// The receiver cannot stall: results must be taken when strobe is high.
module number_to_ascii_digits import n2a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output res_t result
);

	logic valid_s1;
	req_t req_s1;
	logic take;
	logic accept;

	n2a_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s1),
		.in_req  (req_s1),
		.take    (take),
		.strobe  (strobe),
		.result  (result)
	);

	assign busy   = valid_s1 && !take;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

endmodule

/* design/n2a_checker.sv */
// Port-level checks for number_to_ascii_digits, bound to the top level.
// Uses n2a_pkg.
module n2a_checker import n2a_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic strobe,
	input res_t result
);

	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown(req))
		else $error("unknown request accepted");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.ascii_char >= 7'd48 && result.ascii_char <= 7'd57) ||
			(result.ascii_char >= 7'd65 && result.ascii_char <= 7'd70)))
		else $error("character out of range");

	a_chars_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_char |=> strobe)
		else $error("gap inside a number");

	a_busy_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("busy while nothing is emitted");

endmodule

bind number_to_ascii_digits n2a_checker u_n2a_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.strobe(strobe),
	.result(result)
);
